[rtl/sbfr_pkg.sv]
`timescale 1ns / 1ps
// sbfr_pkg: shared types, constants and helpers of the s.bus frame receiver
package sbfr_pkg;

	// frame layout
	localparam int unsigned FrameLen = 25;
	localparam int unsigned AddrW = $clog2(FrameLen);
	localparam logic [AddrW-1:0] PayloadStart = AddrW'(1);
	localparam logic [AddrW-1:0] FlagsPos = AddrW'(23);
	localparam logic [AddrW-1:0] FooterPos = AddrW'(24);

	// byte codes
	localparam logic [7:0] Header = 8'h0F;
	localparam logic [7:0] Footer0 = 8'h00;
	localparam logic [7:0] Footer1 = 8'h04;
	localparam logic [7:0] Footer2 = 8'h14;
	localparam logic [7:0] Footer3 = 8'h24;
	localparam logic [7:0] Footer4 = 8'h34;

	// channel decoding
	localparam int unsigned ChanBits = 11;
	localparam logic [ChanBits-1:0] RawMask = 11'h7FF;
	localparam logic [4:0] NumAnalog = 5'd16;
	localparam logic [4:0] LastChan = 5'd17;
	localparam logic [11:0] PwmOffset = 12'd874;
	localparam logic [11:0] DigitalOn = 12'd1998;
	localparam logic [11:0] DigitalOff = 12'd998;
	localparam logic [15:0] GapReset = 16'd4000;

	// input transaction
	typedef struct packed {
		logic [63:0] arrival_time_us;
		logic [7:0]  rx_byte;
	} byte_t;

	// result transaction
	typedef struct packed {
		logic [4:0]  channel_index;
		logic [11:0] channel_value;
		logic        failsafe;
		logic        link_lost;
		logic        last_of_frame;
	} chan_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic ptr_init;
		logic load;
		logic emit;
		logic step;
		logic copy_wr;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic frame_ok;
		logic frame_bad;
		logic acc_ready;
		logic ch_digital;
		logic ch_last;
		logic hdr_hit;
		logic ptr_last;
		logic out_free;
	} sts_t;

	function automatic logic footer_ok(input logic [7:0] f);
		return (f == Footer0) || (f == Footer1) || (f == Footer2) ||
			(f == Footer3) || (f == Footer4);
	endfunction

	// pwm = ((raw * 5) + 4) / 8 + 874
	function automatic logic [11:0] to_pwm(input logic [ChanBits-1:0] raw);
		logic [13:0] prod;
		prod = {3'b000, raw} + {1'b0, raw, 2'b00} + 14'd4;
		return {1'b0, prod[13:3]} + PwmOffset;
	endfunction

endpackage

[rtl/sbfr_datapath.sv]
`timescale 1ns / 1ps
// sbfr_datapath: frame buffer, framing counters, bit unpacker and result register
module sbfr_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  sbfr_pkg::cmd_t      cmd,
	output sbfr_pkg::sts_t      sts,
	input  sbfr_pkg::byte_t     byte_data,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	output logic                chan_valid,
	input  logic                chan_stall,
	output sbfr_pkg::chan_t     chan_data
);

	localparam int unsigned AW = sbfr_pkg::AddrW;

	logic [7:0]    mem [sbfr_pkg::FrameLen];
	logic [7:0]    rd_q;
	logic [AW-1:0] fill_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] dst_q;
	logic [4:0]    ch_q;
	logic [4:0]    nbits_q;
	logic [17:0]   acc_q;
	logic [63:0]   last_time_q;
	logic [15:0]   gap_q;
	logic [3:0]    flags_q;
	sbfr_pkg::chan_t out_q;
	logic          out_valid_q;

	logic [64:0]   diff;
	logic          gap_hit;
	logic [AW-1:0] eff_fill;
	logic          wr_acc;
	logic          completes;
	logic [11:0]   value;

	// silence gap check against the previous arrival time
	assign diff = {1'b0, byte_data.arrival_time_us} - {1'b0, last_time_q};
	assign gap_hit = (last_time_q != 64'd0) && !diff[64] &&
		(diff[63:0] > {48'd0, gap_q}) && (fill_q != '0);
	assign eff_fill = gap_hit ? '0 : fill_q;
	assign wr_acc = cmd.accept && ((eff_fill != '0) || (byte_data.rx_byte == sbfr_pkg::Header));
	assign completes = (eff_fill == sbfr_pkg::FooterPos);

	// frame buffer, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_acc) begin
			mem[eff_fill] <= byte_data.rx_byte;
		end else if (cmd.copy_wr) begin
			mem[dst_q] <= rd_q;
		end
		rd_q <= mem[ptr_q];
	end

	// fill count, timestamp and gap register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			last_time_q <= '0;
			gap_q <= sbfr_pkg::GapReset;
		end else begin
			if (cmd.accept) begin
				last_time_q <= byte_data.arrival_time_us;
				if (!wr_acc || completes) begin
					fill_q <= '0;
				end else begin
					fill_q <= eff_fill + AW'(1);
				end
			end else if (cmd.copy_wr && sts.ptr_last) begin
				fill_q <= dst_q + AW'(1);
			end
			if (cfg_we) begin
				gap_q <= cfg_wdata;
			end
		end
	end

	// flags byte is captured whenever buffer position 23 is written
	always_ff @(posedge clk) begin
		if (wr_acc && (eff_fill == sbfr_pkg::FlagsPos)) begin
			flags_q <= byte_data.rx_byte[3:0];
		end else if (cmd.copy_wr && (dst_q == sbfr_pkg::FlagsPos)) begin
			flags_q <= rd_q[3:0];
		end
	end

	// read pointer, copy target and bit unpacker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			dst_q <= '0;
			ch_q <= '0;
			nbits_q <= '0;
			acc_q <= '0;
		end else begin
			if (cmd.ptr_init) begin
				ptr_q <= sbfr_pkg::PayloadStart;
				dst_q <= '0;
				ch_q <= '0;
				nbits_q <= '0;
				acc_q <= '0;
			end
			if (cmd.load) begin
				acc_q <= acc_q | (18'(rd_q) << nbits_q);
				nbits_q <= nbits_q + 5'd8;
				ptr_q <= ptr_q + AW'(1);
			end
			if (cmd.step) begin
				ptr_q <= ptr_q + AW'(1);
			end
			if (cmd.copy_wr) begin
				dst_q <= dst_q + AW'(1);
				if (!sts.ptr_last) begin
					ptr_q <= ptr_q + AW'(1);
				end
			end
			if (cmd.emit) begin
				ch_q <= ch_q + 5'd1;
				if (!sts.ch_digital) begin
					acc_q <= acc_q >> sbfr_pkg::ChanBits;
					nbits_q <= nbits_q - 5'(sbfr_pkg::ChanBits);
				end
			end
		end
	end

	// value of the channel being emitted
	always_comb begin
		if (ch_q == sbfr_pkg::NumAnalog) begin
			value = flags_q[0] ? sbfr_pkg::DigitalOn : sbfr_pkg::DigitalOff;
		end else if (ch_q == sbfr_pkg::LastChan) begin
			value = flags_q[1] ? sbfr_pkg::DigitalOn : sbfr_pkg::DigitalOff;
		end else begin
			value = sbfr_pkg::to_pwm(acc_q[sbfr_pkg::ChanBits-1:0] & sbfr_pkg::RawMask);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.channel_index <= ch_q;
			out_q.channel_value <= value;
			out_q.failsafe <= flags_q[3];
			out_q.link_lost <= flags_q[3] | flags_q[2];
			out_q.last_of_frame <= (ch_q == sbfr_pkg::LastChan);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!chan_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign chan_valid = out_valid_q;
	assign chan_data = out_q;

	// status toward the controller
	always_comb begin
		sts.frame_ok = completes && sbfr_pkg::footer_ok(byte_data.rx_byte);
		sts.frame_bad = completes && !sbfr_pkg::footer_ok(byte_data.rx_byte);
		sts.acc_ready = (nbits_q >= 5'(sbfr_pkg::ChanBits));
		sts.ch_digital = (ch_q >= sbfr_pkg::NumAnalog);
		sts.ch_last = (ch_q == sbfr_pkg::LastChan);
		sts.hdr_hit = (rd_q == sbfr_pkg::Header);
		sts.ptr_last = (ptr_q == sbfr_pkg::FooterPos);
		sts.out_free = !out_valid_q || !chan_stall;
	end

	// checks
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < AW'(sbfr_pkg::FrameLen))
		else $error("fill count out of range");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= sbfr_pkg::FooterPos)
		else $error("read pointer out of range");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result register overwritten");
	a_emit_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !sts.ch_digital) |-> sts.acc_ready)
		else $error("analog channel emitted with too few bits");
	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (nbits_q < 5'(sbfr_pkg::ChanBits)))
		else $error("unpacker overflow");

endmodule

[rtl/sbfr_ctrl.sv]
`timescale 1ns / 1ps
// sbfr_ctrl: controller sequencing byte intake, frame decode and resync copy
module sbfr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_stall,
	input  sbfr_pkg::sts_t  sts,
	output sbfr_pkg::cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_DEC_RD   = 8'b0000_0010,
		S_DEC_LD   = 8'b0000_0100,
		S_DEC_EMIT = 8'b0000_1000,
		S_SCAN_RD  = 8'b0001_0000,
		S_SCAN_CHK = 8'b0010_0000,
		S_COPY_RD  = 8'b0100_0000,
		S_COPY_WR  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = byte_valid;
				if (byte_valid && sts.frame_ok) begin
					cmd.ptr_init = 1'b1;
					state_d = S_DEC_RD;
				end else if (byte_valid && sts.frame_bad) begin
					cmd.ptr_init = 1'b1;
					state_d = S_SCAN_RD;
				end
			end
			S_DEC_RD: begin
				state_d = S_DEC_LD;
			end
			S_DEC_LD: begin
				cmd.load = 1'b1;
				state_d = S_DEC_EMIT;
			end
			S_DEC_EMIT: begin
				if (sts.ch_digital || sts.acc_ready) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						if (sts.ch_last) begin
							state_d = S_IDLE;
						end
					end
				end else begin
					state_d = S_DEC_RD;
				end
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (sts.hdr_hit) begin
					state_d = S_COPY_RD;
				end else if (sts.ptr_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.step = 1'b1;
					state_d = S_SCAN_RD;
				end
			end
			S_COPY_RD: begin
				state_d = S_COPY_WR;
			end
			S_COPY_WR: begin
				cmd.copy_wr = 1'b1;
				state_d = sts.ptr_last ? S_IDLE : S_COPY_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign byte_stall = (state_q != S_IDLE);

endmodule

[rtl/sbus_frame_receiver_core.sv]
`timescale 1ns / 1ps
// a byte is taken while the controller is idle; byte_stall is high in every other state.
// after a good footer byte the decoder emits all 18 results of the frame, holding on chan_stall.
// throughput: one byte per cycle while framing; after a complete frame the decode sequencer
// reads the 22 payload bytes from the buffer ram, loading each into the unpacker in turn.
// after a bad footer the resync scan and copy run on the same port.
// reset: asynchronous, active low; framing restarts empty and the gap register reads 4000.
module sbus_frame_receiver_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  sbfr_pkg::byte_t     byte_data,
	output logic                chan_valid,
	input  logic                chan_stall,
	output sbfr_pkg::chan_t     chan_data,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata
);

	sbfr_pkg::cmd_t cmd;
	sbfr_pkg::sts_t sts;

	// controller
	sbfr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// datapath
	sbfr_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.byte_data  (byte_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.chan_valid (chan_valid),
		.chan_stall (chan_stall),
		.chan_data  (chan_data)
	);

endmodule
